// ===== design/euler_fly_camera_update_macros.svh =====
// ----------------------------------------------------------------------------
// euler_fly_camera_update_macros.svh
// Assertion shorthands shared by the camera update RTL.
// ----------------------------------------------------------------------------
`ifndef EULER_FLY_CAMERA_UPDATE_MACROS_SVH
`define EULER_FLY_CAMERA_UPDATE_MACROS_SVH

// same-cycle implication, masked in reset
`define EFC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked in reset
`define EFC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/efc_pkg.sv =====
// ----------------------------------------------------------------------------
// efc_pkg
// Codes, fixed-point constants and small helpers for the fly camera update.
// ----------------------------------------------------------------------------
package efc_pkg;

  // event kinds
  localparam logic [1:0] EV_MOVE = 2'd0;
  localparam logic [1:0] EV_LOOK = 2'd1;
  localparam logic [1:0] EV_ZOOM = 2'd2;

  // move directions
  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_LEFT  = 3'd2;
  localparam logic [2:0] DIR_RIGHT = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  // configuration register indexes
  localparam logic CFG_SPEED = 1'b0;
  localparam logic CFG_SENS  = 1'b1;

  // angles, Q8.7 degrees, held at 18 bits for sums
  localparam logic signed [17:0] ANG_HALF  = 18'sd23040;
  localparam logic signed [17:0] ANG_FULL  = 18'sd46080;
  localparam logic signed [17:0] PITCH_LIM = 18'sd11392;
  localparam logic signed [15:0] YAW_RESET = -16'sd11520;

  localparam logic [12:0] FOV_MIN = 13'd128;
  localparam logic [12:0] FOV_MAX = 13'd5760;

  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // rotation unit, angles in 2^-20 degree
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] DEG90_FINE  = 32'sd94371840;
  localparam logic signed [31:0] DEG180_FINE = 32'sd188743680;

  localparam int ATAN_N = 24;
  localparam logic signed [31:0] ATAN_FINE [ATAN_N] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750059,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7
  };

  // datapath widths
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int NUM_W  = 47;
  localparam int QUO_W  = 16;

  // divide by 2^n (n >= 1), round to nearest, ties away from zero
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                   input logic [4:0] n);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + (66'd1 << (n - 5'd1))) >> n;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  // fold an angle sum back into [-180, 180) degrees
  function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] w;
    if (a >= ANG_HALF) begin
      w = a - ANG_FULL;
    end else if (a < -ANG_HALF) begin
      w = a + ANG_FULL;
    end else begin
      w = a;
    end
    return $signed(w[15:0]);
  endfunction

endpackage

// ===== design/efc_cordic.sv =====
// ----------------------------------------------------------------------------
// efc_cordic
// Iterative rotation-mode sine/cosine, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module efc_cordic #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam logic [4:0] LAST = 5'(TRIG_ITERATIONS - 1);

  logic               busy_r;
  logic               done_r;
  logic               flip_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic signed [31:0] z_r;

  logic signed [31:0] z0;
  logic signed [31:0] dx;
  logic signed [31:0] dy;

  assign z0 = 32'(angle) <<< 13;
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= efc_pkg::CORDIC_GAIN;
        y_r    <= '0;
        // fold into the right half plane, negate at the end
        if (z0 > efc_pkg::DEG90_FINE) begin
          z_r    <= z0 - efc_pkg::DEG180_FINE;
          flip_r <= 1'b1;
        end else if (z0 < -efc_pkg::DEG90_FINE) begin
          z_r    <= z0 + efc_pkg::DEG180_FINE;
          flip_r <= 1'b1;
        end else begin
          z_r    <= z0;
          flip_r <= 1'b0;
        end
      end else if (busy_r) begin
        if (!z_r[31]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - efc_pkg::ATAN_FINE[cnt_r];
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + efc_pkg::ATAN_FINE[cnt_r];
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign sin_o = flip_r ? -y_r : y_r;
  assign cos_o = flip_r ? -x_r : x_r;

endmodule

// ===== design/efc_isqrt.sv =====
// ----------------------------------------------------------------------------
// efc_isqrt
// Floor integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module efc_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [efc_pkg::SUM_W-1:0]   value,
  output logic                        done,
  output logic [efc_pkg::ROOT_W-1:0]  root
);

  logic                      busy_r;
  logic                      done_r;
  logic [4:0]                cnt_r;
  logic [efc_pkg::SUM_W-1:0] v_r;
  logic [efc_pkg::SUM_W-1:0] res_r;
  logic [efc_pkg::SUM_W-1:0] bit_r;
  logic [efc_pkg::SUM_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= value;
        res_r  <= '0;
        bit_r  <= efc_pkg::SUM_W'(1) << (efc_pkg::SUM_W - 2);
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[efc_pkg::ROOT_W-1:0];

endmodule

// ===== design/efc_div.sv =====
// ----------------------------------------------------------------------------
// efc_div
// Restoring divider, 16-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module efc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [efc_pkg::NUM_W-1:0]   num,
  input  logic [efc_pkg::ROOT_W-1:0]  den,
  output logic                        done,
  output logic [efc_pkg::QUO_W-1:0]   quo
);

  localparam int RW = efc_pkg::NUM_W + 1;

  logic                      busy_r;
  logic                      done_r;
  logic [3:0]                cnt_r;
  logic [RW-1:0]             rem_r;
  logic [RW-1:0]             dsh_r;
  logic [efc_pkg::QUO_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= RW'(num);
        dsh_r  <= RW'(den) << (efc_pkg::QUO_W - 1);
        q_r    <= '0;
      end else if (busy_r) begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[efc_pkg::QUO_W-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[efc_pkg::QUO_W-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== design/euler_fly_camera_update.sv =====
// ----------------------------------------------------------------------------
// euler_fly_camera_update
// Fly camera pose engine. One word in carries a move, look or zoom event;
// one word out carries the full pose after it (position, front, up, field of
// view, yaw, pitch). Words are handled one at a time: in_stall stays high
// from acceptance until the result has gone into the output register, which
// can hold one finished word while the next event is taken. A zoom or an
// unknown event goes straight to the output stage; a move steps through the
// three coordinates. A look passes the angles through the iterative
// sine/cosine unit one micro-rotation per cycle, then front, right and up are
// each normalised by the shared square root unit and the shared divider. A
// zero-length vector skips its divides. A full output register that is held
// off delays the release of in_stall. All products go through a single
// registered 33x33 multiplier.
// ----------------------------------------------------------------------------
`include "euler_fly_camera_update_macros.svh"

module euler_fly_camera_update #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  // event words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_event_kind,
  input  logic [2:0]         in_move_dir,
  input  logic [15:0]        in_delta_time,
  input  logic signed [15:0] in_look_dx,
  input  logic signed [15:0] in_look_dy,
  input  logic               in_clamp_pitch,
  // pose words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  output logic [12:0]        out_fov_deg,
  output logic signed [15:0] out_yaw_deg,
  output logic signed [15:0] out_pitch_deg
);

  typedef enum logic [4:0] {
    S_IDLE, S_MV_VEL, S_MV_LATCH, S_MV_MUL, S_MV_ACC,
    S_LK_MX, S_LK_MY, S_LK_P,
    S_CS_Y, S_CS_YW, S_CS_P, S_CS_PW,
    S_FV0, S_FV1, S_FV2,
    S_N_SQ, S_N_ADD, S_N_SQRT, S_N_SQW, S_N_DIV, S_N_DW, S_N_NEXT,
    S_UP0, S_UP1, S_UP2, S_UP3, S_UP4,
    S_EMIT
  } state_t;

  // which vector the normaliser is writing
  typedef enum logic [1:0] {NS_FRONT, NS_RIGHT, NS_UP} nsel_t;

  state_t state_r;
  nsel_t  nsel_r;

  // architectural state
  logic [15:0]        speed_r;
  logic [15:0]        sens_r;
  logic signed [31:0] pos_r   [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r    [3];
  logic signed [15:0] yaw_r;
  logic signed [15:0] pitch_r;
  logic [12:0]        fov_r;

  // latched event
  logic [2:0]         dir_r;
  logic [15:0]        dt_r;
  logic signed [15:0] dx_r;
  logic signed [15:0] dy_r;
  logic               clamp_r;

  // working registers
  logic [24:0]        vel_r;
  logic [1:0]         idx_r;
  logic signed [31:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [32:0] v_r [3];
  logic signed [32:0] t_r;
  logic [efc_pkg::SUM_W-1:0]  sum_r;
  logic [efc_pkg::ROOT_W-1:0] len_r;
  logic signed [65:0] mul_p_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic signed [15:0] out_front_x_r, out_front_y_r, out_front_z_r;
  logic signed [15:0] out_up_x_r, out_up_y_r, out_up_z_r;
  logic [12:0]        out_fov_r;
  logic signed [15:0] out_yaw_r, out_pitch_r;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  // sub-unit hookup
  logic               cs_start, cs_done;
  logic signed [15:0] cs_angle;
  logic signed [31:0] cs_sin, cs_cos;
  logic               sq_done;
  logic [efc_pkg::ROOT_W-1:0] sq_root;
  logic               dv_start, dv_done;
  logic [efc_pkg::NUM_W-1:0]  dv_num;
  logic [efc_pkg::QUO_W-1:0]  dv_quo;

  // datapath
  logic               accept;
  logic               emit;
  logic signed [32:0] v_sel, vmag;
  logic signed [15:0] mv_vec;
  logic               mv_neg;
  logic signed [65:0] rs14, rs17, rs30, rsz;
  logic signed [33:0] d34, pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [17:0] off18, yaw_sum, pitch_sum;
  logic signed [15:0] pitch_new;
  logic signed [17:0] zoom_sum;
  logic [12:0]        zoom_fov;
  logic [15:0]        q_cap;
  logic signed [15:0] norm_val;
  logic               norm_wr;

  assign accept = in_valid && (state_r == S_IDLE);
  assign emit   = (state_r == S_EMIT) && !(out_valid_r && out_stall);

  // vector under the normaliser
  assign v_sel = v_r[idx_r];
  assign vmag  = v_sel[32] ? -v_sel : v_sel;

  // move vector and sign by direction
  always_comb begin
    mv_vec = front_r[idx_r];
    mv_neg = 1'b0;
    unique case (dir_r)
      efc_pkg::DIR_FWD:   begin mv_vec = front_r[idx_r]; mv_neg = 1'b0; end
      efc_pkg::DIR_BACK:  begin mv_vec = front_r[idx_r]; mv_neg = 1'b1; end
      efc_pkg::DIR_LEFT:  begin mv_vec = right_r[idx_r]; mv_neg = 1'b1; end
      efc_pkg::DIR_RIGHT: begin mv_vec = right_r[idx_r]; mv_neg = 1'b0; end
      efc_pkg::DIR_UP:    begin mv_vec = up_r[idx_r];    mv_neg = 1'b0; end
      efc_pkg::DIR_DOWN:  begin mv_vec = up_r[idx_r];    mv_neg = 1'b1; end
      default:            begin mv_vec = front_r[idx_r]; mv_neg = 1'b0; end
    endcase
  end

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MV_VEL: begin mul_a = 33'(speed_r);  mul_b = 33'(dt_r);    end
      S_MV_MUL: begin mul_a = 33'(mv_vec);   mul_b = 33'(vel_r);   end
      S_LK_MX:  begin mul_a = 33'(dx_r);     mul_b = 33'(sens_r);  end
      S_LK_MY:  begin mul_a = 33'(dy_r);     mul_b = 33'(sens_r);  end
      S_FV0:    begin mul_a = 33'(cy_r);     mul_b = 33'(cp_r);    end
      S_FV1:    begin mul_a = 33'(sy_r);     mul_b = 33'(cp_r);    end
      S_N_SQ:   begin mul_a = vmag;          mul_b = vmag;         end
      S_UP0:    begin mul_a = 33'(right_r[2]); mul_b = 33'(front_r[1]); end
      S_UP1:    begin mul_a = 33'(right_r[2]); mul_b = 33'(front_r[0]); end
      S_UP2:    begin mul_a = 33'(right_r[0]); mul_b = 33'(front_r[2]); end
      S_UP3:    begin mul_a = 33'(right_r[0]); mul_b = 33'(front_r[1]); end
      default:  begin mul_a = '0;            mul_b = '0;           end
    endcase
  end

  // rounding of the registered product
  assign rs14 = efc_pkg::rnd_shift(mul_p_r, 5'd14);
  assign rs17 = efc_pkg::rnd_shift(mul_p_r, 5'd17);
  assign rs30 = efc_pkg::rnd_shift(mul_p_r, 5'd30);

  // position step with saturation
  assign d34     = $signed(rs14[33:0]);
  assign pos_sum = 34'(pos_r[idx_r]) + (mv_neg ? -d34 : d34);
  always_comb begin
    if (pos_sum > 34'sd2147483647) begin
      pos_sat = 32'sh7fffffff;
    end else if (pos_sum < -34'sd2147483648) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = $signed(pos_sum[31:0]);
    end
  end

  // look offsets; the same rounding serves yaw then pitch
  assign off18     = $signed(rs17[17:0]);
  assign yaw_sum   = 18'(yaw_r) + off18;
  assign pitch_sum = 18'(pitch_r) + off18;
  always_comb begin
    if (!clamp_r) begin
      pitch_new = efc_pkg::wrap_ang(pitch_sum);
    end else if (pitch_sum > efc_pkg::PITCH_LIM) begin
      pitch_new = 16'(efc_pkg::PITCH_LIM);
    end else if (pitch_sum < -efc_pkg::PITCH_LIM) begin
      pitch_new = 16'(-efc_pkg::PITCH_LIM);
    end else begin
      pitch_new = $signed(pitch_sum[15:0]);
    end
  end

  // zoom, worked out straight from the input word
  assign rsz      = efc_pkg::rnd_shift(66'(in_look_dy), 5'd1);
  assign zoom_sum = $signed({5'b0, fov_r}) - $signed(rsz[17:0]);
  always_comb begin
    if (zoom_sum < $signed({5'b0, efc_pkg::FOV_MIN})) begin
      zoom_fov = efc_pkg::FOV_MIN;
    end else if (zoom_sum > $signed({5'b0, efc_pkg::FOV_MAX})) begin
      zoom_fov = efc_pkg::FOV_MAX;
    end else begin
      zoom_fov = zoom_sum[12:0];
    end
  end

  // normalised component: zero length gives a zero vector
  assign q_cap    = (dv_quo > efc_pkg::ONE_Q14) ? efc_pkg::ONE_Q14 : dv_quo;
  assign norm_val = (len_r == '0) ? 16'sd0
                  : (v_sel[32] ? -$signed(q_cap) : $signed(q_cap));
  assign norm_wr  = ((state_r == S_N_DIV) && (len_r == '0)) ||
                    ((state_r == S_N_DW) && dv_done);

  // sub-units
  assign cs_start = (state_r == S_CS_Y) || (state_r == S_CS_P);
  assign cs_angle = (state_r == S_CS_P) ? pitch_r : yaw_r;

  efc_cordic #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .angle (cs_angle),
    .done  (cs_done),
    .sin_o (cs_sin),
    .cos_o (cs_cos)
  );

  efc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_N_SQRT),
    .value (sum_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  // (|v| * 2^14 + len/2) / len
  assign dv_start = (state_r == S_N_DIV) && (len_r != '0);
  assign dv_num   = (efc_pkg::NUM_W'(vmag[31:0]) << 14) + efc_pkg::NUM_W'(len_r >> 1);

  efc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (len_r),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // sequencer and all registers
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nsel_r      <= NS_FRONT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      speed_r     <= 16'd640;
      sens_r      <= 16'd6554;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
      front_r[0]  <= '0;
      front_r[1]  <= '0;
      front_r[2]  <= -$signed(efc_pkg::ONE_Q14);
      right_r[0]  <= $signed(efc_pkg::ONE_Q14);
      right_r[1]  <= '0;
      right_r[2]  <= '0;
      up_r[0]     <= '0;
      up_r[1]     <= $signed(efc_pkg::ONE_Q14);
      up_r[2]     <= '0;
      yaw_r       <= efc_pkg::YAW_RESET;
      pitch_r     <= '0;
      fov_r       <= efc_pkg::FOV_MAX;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          efc_pkg::CFG_SPEED: speed_r <= cfg_data;
          efc_pkg::CFG_SENS:  sens_r  <= cfg_data;
          default: ;
        endcase
      end

      // drained word; a word loaded in the same cycle keeps it set
      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end

      if (norm_wr) begin
        unique case (nsel_r)
          NS_FRONT: front_r[idx_r] <= norm_val;
          NS_RIGHT: right_r[idx_r] <= norm_val;
          NS_UP:    up_r[idx_r]    <= norm_val;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            dir_r   <= in_move_dir;
            dt_r    <= in_delta_time;
            dx_r    <= in_look_dx;
            dy_r    <= in_look_dy;
            clamp_r <= in_clamp_pitch;
            idx_r   <= '0;
            priority if (in_event_kind == efc_pkg::EV_MOVE &&
                         in_move_dir <= efc_pkg::DIR_DOWN) begin
              state_r <= S_MV_VEL;
            end else if (in_event_kind == efc_pkg::EV_LOOK) begin
              state_r <= S_LK_MX;
            end else if (in_event_kind == efc_pkg::EV_ZOOM) begin
              fov_r   <= zoom_fov;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end

        // move: velocity, then one coordinate at a time through multiply and accumulate
        S_MV_VEL:   state_r <= S_MV_LATCH;
        S_MV_LATCH: begin
          vel_r   <= 25'((mul_p_r[32:0] + 33'd128) >> 8);
          state_r <= S_MV_MUL;
        end
        S_MV_MUL:   state_r <= S_MV_ACC;
        S_MV_ACC: begin
          pos_r[idx_r] <= pos_sat;
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_MV_MUL;
          end
        end

        // look: angles first
        S_LK_MX: state_r <= S_LK_MY;
        S_LK_MY: begin
          yaw_r   <= efc_pkg::wrap_ang(yaw_sum);
          state_r <= S_LK_P;
        end
        S_LK_P: begin
          pitch_r <= pitch_new;
          state_r <= S_CS_Y;
        end

        S_CS_Y:  state_r <= S_CS_YW;
        S_CS_YW: begin
          if (cs_done) begin
            sy_r    <= cs_sin;
            cy_r    <= cs_cos;
            state_r <= S_CS_P;
          end
        end
        S_CS_P:  state_r <= S_CS_PW;
        S_CS_PW: begin
          if (cs_done) begin
            sp_r    <= cs_sin;
            cp_r    <= cs_cos;
            state_r <= S_FV0;
          end
        end

        // raw front = (cy*cp, sp, sy*cp)
        S_FV0: state_r <= S_FV1;
        S_FV1: begin
          v_r[0]  <= $signed(rs30[32:0]);
          state_r <= S_FV2;
        end
        S_FV2: begin
          v_r[2]  <= $signed(rs30[32:0]);
          v_r[1]  <= 33'(sp_r);
          nsel_r  <= NS_FRONT;
          idx_r   <= '0;
          state_r <= S_N_SQ;
        end

        // normaliser: squares, root, three divides
        S_N_SQ: state_r <= S_N_ADD;
        S_N_ADD: begin
          sum_r <= ((idx_r == 2'd0) ? '0 : sum_r) + mul_p_r[efc_pkg::SUM_W-1:0];
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_N_SQRT;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_N_SQ;
          end
        end
        S_N_SQRT: state_r <= S_N_SQW;
        S_N_SQW: begin
          if (sq_done) begin
            len_r   <= sq_root;
            state_r <= S_N_DIV;
          end
        end
        S_N_DIV: state_r <= (len_r == '0) ? S_N_NEXT : S_N_DW;
        S_N_DW: begin
          if (dv_done) begin
            state_r <= S_N_NEXT;
          end
        end
        S_N_NEXT: begin
          if (idx_r == 2'd2) begin
            idx_r <= '0;
            unique case (nsel_r)
              NS_FRONT: begin
                // right from the new front: (-fz, 0, fx)
                v_r[0]  <= -33'(front_r[2]);
                v_r[1]  <= '0;
                v_r[2]  <= 33'(front_r[0]);
                nsel_r  <= NS_RIGHT;
                state_r <= S_N_SQ;
              end
              NS_RIGHT: state_r <= S_UP0;
              default:  state_r <= S_EMIT;
            endcase
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_N_DIV;
          end
        end

        // up = right x front, world-up terms dropped since right_y is zero
        S_UP0: state_r <= S_UP1;
        S_UP1: begin
          v_r[0]  <= -$signed(mul_p_r[32:0]);
          state_r <= S_UP2;
        end
        S_UP2: begin
          t_r     <= $signed(mul_p_r[32:0]);
          state_r <= S_UP3;
        end
        S_UP3: begin
          v_r[1]  <= t_r - $signed(mul_p_r[32:0]);
          state_r <= S_UP4;
        end
        S_UP4: begin
          v_r[2]  <= $signed(mul_p_r[32:0]);
          nsel_r  <= NS_UP;
          idx_r   <= '0;
          state_r <= S_N_SQ;
        end

        S_EMIT: begin
          if (emit) begin
            out_valid_r   <= 1'b1;
            out_pos_x_r   <= pos_r[0];
            out_pos_y_r   <= pos_r[1];
            out_pos_z_r   <= pos_r[2];
            out_front_x_r <= front_r[0];
            out_front_y_r <= front_r[1];
            out_front_z_r <= front_r[2];
            out_up_x_r    <= up_r[0];
            out_up_y_r    <= up_r[1];
            out_up_z_r    <= up_r[2];
            out_fov_r     <= fov_r;
            out_yaw_r     <= yaw_r;
            out_pitch_r   <= pitch_r;
            state_r       <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_pos_x_r;
  assign out_pos_y     = out_pos_y_r;
  assign out_pos_z     = out_pos_z_r;
  assign out_front_x   = out_front_x_r;
  assign out_front_y   = out_front_y_r;
  assign out_front_z   = out_front_z_r;
  assign out_up_x      = out_up_x_r;
  assign out_up_y      = out_up_y_r;
  assign out_up_z      = out_up_z_r;
  assign out_fov_deg   = out_fov_r;
  assign out_yaw_deg   = out_yaw_r;
  assign out_pitch_deg = out_pitch_r;

  // checks
  `EFC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted word did not make the block busy")
  `EFC_ASSERT_SAME(a_fov_range, clk, rst_n, 1'b1, fov_r >= efc_pkg::FOV_MIN && fov_r <= efc_pkg::FOV_MAX, "fov left its range")
  `EFC_ASSERT_SAME(a_yaw_range, clk, rst_n, 1'b1, yaw_r >= -efc_pkg::ANG_HALF && yaw_r < efc_pkg::ANG_HALF, "yaw not wrapped")
  `EFC_ASSERT_NEXT(a_emit_loads, clk, rst_n, emit, out_valid && !in_stall, "finished pose not presented")

endmodule
